@@ src/sexpr_char_tokenizer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the tokenizer checker
// Implication forms with an active-high disable.
// ----------------------------------------------------------------------------
`ifndef SEXPR_CHAR_TOKENIZER_TOP_DEFINES_SVH
`define SEXPR_CHAR_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define SCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Token kinds, scan modes and character classes of the s-expression tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int CHAR_WIDTH       = 8;
   localparam int KIND_WIDTH       = 4;
   localparam int VALUE_WIDTH      = 64;
   localparam int FRAC_VALUE_WIDTH = 60;
   localparam int FRAC_COUNT_WIDTH = 5;

   // token kinds
   localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 4'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 4'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_LBRACK = 4'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_RBRACK = 4'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_LBRACE = 4'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_RBRACE = 4'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_COLON  = 4'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_STAR   = 4'd7;
   localparam logic [KIND_WIDTH-1:0] KIND_INT32  = 4'd8;
   localparam logic [KIND_WIDTH-1:0] KIND_INT64  = 4'd9;
   localparam logic [KIND_WIDTH-1:0] KIND_FRAC   = 4'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_SYM    = 4'd11;
   localparam logic [KIND_WIDTH-1:0] KIND_ERROR  = 4'd12;
   localparam logic [KIND_WIDTH-1:0] KIND_DONE   = 4'd13;

   // request function codes
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // integers at or above this (top bit clear) tag as 64-bit
   localparam logic [VALUE_WIDTH-1:0] INT32_LIMIT = 64'd2147483647;

   // character codes
   localparam logic [CHAR_WIDTH-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_WIDTH-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CH_UNDER  = 8'h5F;
   localparam logic [CHAR_WIDTH-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_LOW_A  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_LOW_Z  = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_WIDTH-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_WIDTH-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_WIDTH-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_WIDTH-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_WIDTH-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CHAR_WIDTH-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_WIDTH-1:0] CH_STAR   = 8'h2A;

   // scan modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_INT     = 3'd2,
      MODE_FRAC    = 3'd3,
      MODE_SYM     = 3'd4,
      MODE_ERROR   = 3'd5
   } mode_type;

   // one-character token lookup: hit flag and kind
   typedef struct packed {
      logic                  hit;
      logic [KIND_WIDTH-1:0] kind;
   } single_type;

   function automatic single_type single_lookup(input logic [CHAR_WIDTH-1:0] c);
      single_type r;
      r.hit  = 1'b1;
      r.kind = KIND_LPAREN;
      case (c)
         CH_LPAREN: r.kind = KIND_LPAREN;
         CH_RPAREN: r.kind = KIND_RPAREN;
         CH_LBRACK: r.kind = KIND_LBRACK;
         CH_RBRACK: r.kind = KIND_RBRACK;
         CH_LBRACE: r.kind = KIND_LBRACE;
         CH_RBRACE: r.kind = KIND_RBRACE;
         CH_COLON:  r.kind = KIND_COLON;
         CH_STAR:   r.kind = KIND_STAR;
         default:   r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ src/sexpr_char_tokenizer_top.sv @@
// Path: input register, then decode into the 4-entry response queue.
// Throughput: one character per cycle while the queue holds two or fewer
//   entries; a character that yields two tokens takes two beats of the
//   response port, which moves one beat per cycle while rsp_ready is high.
// Reset: synchronous; empties the queue, scan mode idle, line 1, offset 0.
// ----------------------------------------------------------------------------
// sexpr_char_tokenizer_top
// Streams characters into bracket, colon, star, number, fraction and symbol tokens,
// with comment and whitespace skipping, line and offset tracking.
// ----------------------------------------------------------------------------
module sexpr_char_tokenizer_top #(
   parameter int POS_WIDTH       = 32,
   parameter int LINE_WIDTH      = 24,
   parameter int MAX_FRAC_DIGITS = 18
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [sct_pkg::CHAR_WIDTH-1:0]         req_ch,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sct_pkg::KIND_WIDTH-1:0]         rsp_kind,
   output logic signed [sct_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic [sct_pkg::FRAC_VALUE_WIDTH-1:0]   rsp_frac_value,
   output logic [sct_pkg::FRAC_COUNT_WIDTH-1:0]   rsp_frac_count,
   output logic                                   rsp_symbol_end,
   output logic [LINE_WIDTH-1:0]                  rsp_line_number,
   output logic [POS_WIDTH-1:0]                   rsp_start_pos,
   output logic [POS_WIDTH-1:0]                   rsp_end_pos,
   output logic                                   rsp_last_of_run
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      logic [sct_pkg::KIND_WIDTH-1:0]       kind;
      logic [sct_pkg::VALUE_WIDTH-1:0]      value;
      logic [sct_pkg::FRAC_VALUE_WIDTH-1:0] frac_value;
      logic [sct_pkg::FRAC_COUNT_WIDTH-1:0] frac_count;
      logic                                 symbol_end;
      logic [LINE_WIDTH-1:0]                line_number;
      logic [POS_WIDTH-1:0]                 start_pos;
      logic [POS_WIDTH-1:0]                 end_pos;
      logic                                 last_of_run;
   } rsp_type;

   // input register
   logic                                  in_valid_ff, in_valid_in;
   logic                                  in_func_ff;
   logic [sct_pkg::CHAR_WIDTH-1:0]        in_ch_ff;

   // scan state
   sct_pkg::mode_type                     mode_ff, mode_in;
   logic [sct_pkg::VALUE_WIDTH-1:0]       int_ff, int_in;
   logic [sct_pkg::FRAC_VALUE_WIDTH-1:0]  frac_ff, frac_in;
   logic [sct_pkg::FRAC_COUNT_WIDTH-1:0]  fdig_ff, fdig_in;
   logic [sct_pkg::CHAR_WIDTH-1:0]        pend_ff, pend_in;
   logic [LINE_WIDTH-1:0]                 line_ff, line_in;
   logic [POS_WIDTH-1:0]                  pos_ff, pos_in;
   logic [POS_WIDTH-1:0]                  tstart_ff, tstart_in;

   // response queue
   rsp_type                               q_ff [QDEPTH];
   logic [QPTR_W-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]                     wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0]                     cnt_ff, cnt_in;

   // decode
   logic                                  proc;
   logic                                  pop;
   logic [sct_pkg::CHAR_WIDTH-1:0]        c;
   logic                                  c_dig, c_alpha, c_ws, c_hash, c_nl, c_dot;
   logic                                  c_symc;
   sct_pkg::single_type                   c_single;
   logic [sct_pkg::CHAR_WIDTH-1:0]        c_digit;
   logic                                  do_start;
   logic [LINE_WIDTH-1:0]                 line_adv;
   logic [POS_WIDTH-1:0]                  pos_adv;
   logic [sct_pkg::VALUE_WIDTH-1:0]       int_mac;
   logic [sct_pkg::FRAC_VALUE_WIDTH-1:0]  frac_mac;
   logic                                  int_big;

   // results of this item
   logic                                  a_v, b_v;
   rsp_type                               res_a, res_b, ent0, ent1;
   logic [1:0]                            n_res;

   // handshake: the queue takes two entries whenever it holds two or fewer
   assign pop         = rsp_valid && rsp_ready;
   assign proc        = in_valid_ff && (cnt_ff <= QCNT_W'(QDEPTH - 2));
   assign req_ready   = !in_valid_ff || proc;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_ch_ff   <= req_ch;
      end
   end

   // character classes
   assign c        = in_ch_ff;
   assign c_dig    = (c >= sct_pkg::CH_ZERO) && (c <= sct_pkg::CH_NINE);
   assign c_alpha  = ((c >= sct_pkg::CH_LOW_A) && (c <= sct_pkg::CH_LOW_Z)) ||
                     ((c >= sct_pkg::CH_UP_A) && (c <= sct_pkg::CH_UP_Z));
   assign c_ws     = (c == sct_pkg::CH_SPACE) ||
                     ((c >= sct_pkg::CH_TAB) && (c <= sct_pkg::CH_CR));
   assign c_hash   = (c == sct_pkg::CH_HASH);
   assign c_nl     = (c == sct_pkg::CH_NL);
   assign c_dot    = (c == sct_pkg::CH_DOT);
   assign c_symc   = c_dig || c_alpha || (c == sct_pkg::CH_UNDER);
   assign c_single = sct_pkg::single_lookup(c);
   assign c_digit  = c - sct_pkg::CH_ZERO;

   // saturating line and offset advance
   assign line_adv = (c_nl && (line_ff != {LINE_WIDTH{1'b1}})) ?
                     line_ff + LINE_WIDTH'(1) : line_ff;
   assign pos_adv  = (pos_ff != {POS_WIDTH{1'b1}}) ? pos_ff + POS_WIDTH'(1) : pos_ff;

   // times-ten accumulate as shift and add
   assign int_mac  = (int_ff << 3) + (int_ff << 1) +
                     sct_pkg::VALUE_WIDTH'(c_digit[3:0]);
   assign frac_mac = (frac_ff << 3) + (frac_ff << 1) +
                     sct_pkg::FRAC_VALUE_WIDTH'(c_digit[3:0]);
   assign int_big  = !int_ff[sct_pkg::VALUE_WIDTH-1] && (int_ff >= sct_pkg::INT32_LIMIT);

   // the character ends the open token (if any) and starts a new one
   always_comb begin
      do_start = 1'b0;
      case (mode_ff)
         sct_pkg::MODE_COMMENT: do_start = 1'b0;
         sct_pkg::MODE_ERROR:   do_start = 1'b0;
         sct_pkg::MODE_INT:     do_start = !c_dig && !c_dot && !c_alpha;
         sct_pkg::MODE_FRAC:    do_start = !c_dig && !c_alpha;
         sct_pkg::MODE_SYM:     do_start = !c_symc;
         default:               do_start = 1'b1;
      endcase
   end

   // next scan state
   always_comb begin
      mode_in   = mode_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      fdig_in   = fdig_ff;
      pend_in   = pend_ff;
      line_in   = line_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      if (in_func_ff == sct_pkg::FUNC_END) begin
         mode_in   = sct_pkg::MODE_IDLE;
         line_in   = {{(LINE_WIDTH-1){1'b0}}, 1'b1};
         pos_in    = '0;
         tstart_in = '0;
      end else begin
         case (mode_ff)
            sct_pkg::MODE_COMMENT: begin
               if (c_nl) begin
                  mode_in = sct_pkg::MODE_IDLE;
               end
               line_in = line_adv;
               pos_in  = pos_adv;
            end
            sct_pkg::MODE_INT: begin
               if (c_dig) begin
                  int_in  = int_mac;
                  line_in = line_adv;
                  pos_in  = pos_adv;
               end else if (c_dot) begin
                  mode_in = sct_pkg::MODE_FRAC;
                  frac_in = '0;
                  fdig_in = '0;
                  line_in = line_adv;
                  pos_in  = pos_adv;
               end else if (c_alpha) begin
                  mode_in = sct_pkg::MODE_ERROR;
               end
            end
            sct_pkg::MODE_FRAC: begin
               if (c_dig) begin
                  if (fdig_ff < sct_pkg::FRAC_COUNT_WIDTH'(MAX_FRAC_DIGITS)) begin
                     frac_in = frac_mac;
                     fdig_in = fdig_ff + sct_pkg::FRAC_COUNT_WIDTH'(1);
                  end
                  line_in = line_adv;
                  pos_in  = pos_adv;
               end else if (c_alpha) begin
                  mode_in = sct_pkg::MODE_ERROR;
               end
            end
            sct_pkg::MODE_SYM: begin
               if (c_symc) begin
                  pend_in = c;
                  line_in = line_adv;
                  pos_in  = pos_adv;
               end
            end
            default: begin
            end
         endcase
         // open a new token
         if (do_start) begin
            mode_in = sct_pkg::MODE_IDLE;
            line_in = line_adv;
            pos_in  = pos_adv;
            if (c_hash) begin
               mode_in = sct_pkg::MODE_COMMENT;
            end else if (c_single.hit) begin
               tstart_in = pos_ff;
            end else if (c_dig) begin
               tstart_in = pos_ff;
               int_in    = sct_pkg::VALUE_WIDTH'(c_digit[3:0]);
               mode_in   = sct_pkg::MODE_INT;
            end else if (!c_ws) begin
               tstart_in = pos_ff;
               pend_in   = c;
               mode_in   = sct_pkg::MODE_SYM;
            end
         end
      end
   end

   // results: a is a number or symbol character, b is a one-char token or done
   always_comb begin
      a_v   = 1'b0;
      b_v   = 1'b0;
      res_a = '0;
      res_b = '0;
      res_a.line_number = line_ff;
      res_a.start_pos   = tstart_ff;
      res_a.end_pos     = pos_ff;
      res_b.line_number = line_ff;
      case (mode_ff)
         sct_pkg::MODE_INT: begin
            a_v = (in_func_ff == sct_pkg::FUNC_END) || (!c_dig && !c_dot);
            res_a.value = int_ff;
            if ((in_func_ff == sct_pkg::FUNC_CHAR) && c_alpha) begin
               res_a.kind = sct_pkg::KIND_ERROR;
            end else begin
               res_a.kind = int_big ? sct_pkg::KIND_INT64 : sct_pkg::KIND_INT32;
            end
         end
         sct_pkg::MODE_FRAC: begin
            a_v = (in_func_ff == sct_pkg::FUNC_END) || !c_dig;
            res_a.value = int_ff;
            if ((in_func_ff == sct_pkg::FUNC_CHAR) && c_alpha) begin
               res_a.kind = sct_pkg::KIND_ERROR;
            end else begin
               res_a.kind       = sct_pkg::KIND_FRAC;
               res_a.frac_value = frac_ff;
               res_a.frac_count = fdig_ff;
            end
         end
         sct_pkg::MODE_SYM: begin
            a_v              = 1'b1;
            res_a.kind       = sct_pkg::KIND_SYM;
            res_a.value      = sct_pkg::VALUE_WIDTH'(pend_ff);
            res_a.symbol_end = (in_func_ff == sct_pkg::FUNC_END) || !c_symc;
         end
         default: begin
         end
      endcase
      if (in_func_ff == sct_pkg::FUNC_END) begin
         b_v             = 1'b1;
         res_b.kind      = sct_pkg::KIND_DONE;
         res_b.start_pos = pos_ff;
         res_b.end_pos   = pos_ff;
      end else begin
         b_v             = do_start && c_single.hit;
         res_b.kind      = c_single.kind;
         res_b.value     = sct_pkg::VALUE_WIDTH'(c);
         res_b.start_pos = pos_ff;
         res_b.end_pos   = pos_adv;
      end
   end

   // pack results into queue order
   always_comb begin
      n_res = 2'(a_v) + 2'(b_v);
      ent0  = a_v ? res_a : res_b;
      ent1  = res_b;
      ent0.last_of_run = (n_res == 2'd1);
      ent1.last_of_run = 1'b1;
   end

   // queue pointers and fill count
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (proc) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(n_res);
      end
      cnt_in = cnt_ff - QCNT_W'(pop) + (proc ? QCNT_W'(n_res) : QCNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sct_pkg::MODE_IDLE;
         line_ff   <= {{(LINE_WIDTH-1){1'b0}}, 1'b1};
         pos_ff    <= '0;
         tstart_ff <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (proc) begin
            mode_ff   <= mode_in;
            line_ff   <= line_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // accumulators and queue entries carry no reset
   always_ff @(posedge clock) begin
      if (proc) begin
         int_ff  <= int_in;
         frac_ff <= frac_in;
         fdig_ff <= fdig_in;
         pend_ff <= pend_in;
         if (n_res != 2'd0) begin
            q_ff[wr_ptr_ff] <= ent0;
         end
         if (n_res == 2'd2) begin
            q_ff[wr_ptr_ff + QPTR_W'(1)] <= ent1;
         end
      end
   end

   // response port from queue head
   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_kind        = q_ff[rd_ptr_ff].kind;
   assign rsp_value       = q_ff[rd_ptr_ff].value;
   assign rsp_frac_value  = q_ff[rd_ptr_ff].frac_value;
   assign rsp_frac_count  = q_ff[rd_ptr_ff].frac_count;
   assign rsp_symbol_end  = q_ff[rd_ptr_ff].symbol_end;
   assign rsp_line_number = q_ff[rd_ptr_ff].line_number;
   assign rsp_start_pos   = q_ff[rd_ptr_ff].start_pos;
   assign rsp_end_pos     = q_ff[rd_ptr_ff].end_pos;
   assign rsp_last_of_run = q_ff[rd_ptr_ff].last_of_run;

endmodule

@@ src/sct_checker.sv @@
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the tokenizer response stream.
// ----------------------------------------------------------------------------
`include "sexpr_char_tokenizer_top_defines.svh"

module sct_checker #(
   parameter int POS_WIDTH  = 32,
   parameter int LINE_WIDTH = 24
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [sct_pkg::KIND_WIDTH-1:0]         rsp_kind,
   input logic signed [sct_pkg::VALUE_WIDTH-1:0] rsp_value,
   input logic [sct_pkg::FRAC_VALUE_WIDTH-1:0]   rsp_frac_value,
   input logic [sct_pkg::FRAC_COUNT_WIDTH-1:0]   rsp_frac_count,
   input logic                                   rsp_symbol_end,
   input logic [LINE_WIDTH-1:0]                  rsp_line_number,
   input logic [POS_WIDTH-1:0]                   rsp_start_pos,
   input logic [POS_WIDTH-1:0]                   rsp_end_pos,
   input logic                                   rsp_last_of_run
);

   // a stalled beat holds its kind, value and end offset
   `SCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_end_pos), "response beat changed while stalled")

   // done closes its run at the current offset
   `SCT_ASSERT_NOW(a_done_beat, clock, reset, rsp_valid && (rsp_kind == sct_pkg::KIND_DONE), rsp_last_of_run && (rsp_value == '0) && (rsp_start_pos == rsp_end_pos), "malformed done beat")

   // fraction fields only on fraction tokens
   `SCT_ASSERT_NOW(a_frac_only, clock, reset, rsp_valid && (rsp_kind != sct_pkg::KIND_FRAC), (rsp_frac_value == '0) && (rsp_frac_count == '0), "fraction fields outside fraction token")

   // symbol end flag only on symbol characters, and those beats never end before they begin
   `SCT_ASSERT_NOW(a_sym_end, clock, reset, rsp_valid && rsp_symbol_end, (rsp_kind == sct_pkg::KIND_SYM) && (rsp_end_pos >= rsp_start_pos), "symbol end on wrong beat")

endmodule

bind sexpr_char_tokenizer_top sct_checker #(
   .POS_WIDTH  (POS_WIDTH),
   .LINE_WIDTH (LINE_WIDTH)
) u_sct_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_value       (rsp_value),
   .rsp_frac_value  (rsp_frac_value),
   .rsp_frac_count  (rsp_frac_count),
   .rsp_symbol_end  (rsp_symbol_end),
   .rsp_line_number (rsp_line_number),
   .rsp_start_pos   (rsp_start_pos),
   .rsp_end_pos     (rsp_end_pos),
   .rsp_last_of_run (rsp_last_of_run)
);
